[hdl/kscc_pkg.sv]
// Package for the keypad-set calendar clock: payload types, key codes,
// error codes and small calendar helpers. No dependencies.
package kscc_pkg;

    typedef struct packed {
        logic       mode;
        logic [4:0] key_code;
    } kscc_in_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        pm_flag;
        logic        twelve_hour;
        logic [1:0]  phase;
        logic [3:0]  digits_entered;
        logic [26:0] entry_value;
        logic [2:0]  error_code;
    } kscc_out_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_SET    = 2'd2,
        CMD_TOGGLE = 2'd3
    } kscc_cmd_t;

    // classified item passed from front to back
    typedef struct packed {
        kscc_cmd_t  cmd;
        logic       is_digit;
        logic [3:0] digit;
    } kscc_op_t;

    localparam logic [4:0] KEY_SET    = 5'd13;
    localparam logic [4:0] KEY_TOGGLE = 5'd4;

    localparam logic [1:0] PH_RUN  = 2'd0;
    localparam logic [1:0] PH_DATE = 2'd1;
    localparam logic [1:0] PH_TIME = 2'd2;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_YEAR   = 3'd1;
    localparam logic [2:0] ERR_MONTH  = 3'd2;
    localparam logic [2:0] ERR_DAY    = 3'd3;
    localparam logic [2:0] ERR_HOUR   = 3'd4;
    localparam logic [2:0] ERR_MINUTE = 3'd5;
    localparam logic [2:0] ERR_SECOND = 3'd6;

    localparam logic [13:0] YEAR_MIN = 14'd1970;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // year held as century and year-in-century, 0..99 each
    localparam logic [6:0] YEAR_HI_MIN = 7'd19;
    localparam logic [6:0] YEAR_LO_MIN = 7'd70;
    localparam logic [6:0] YEAR_PART_MAX = 7'd99;

    function automatic logic is_leap(input logic [6:0] yhi, input logic [6:0] ylo);
        return (ylo == 7'd0) ? (yhi[1:0] == 2'd0) : (ylo[1:0] == 2'd0);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            4'd2:                    r = leap ? 5'd29 : 5'd28;
            default:                 r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

[hdl/kscc_front.sv]
// Front end: accepts input items, decodes key codes, pushes ops to a
// two-entry queue. Depends on kscc_pkg.
module kscc_front import kscc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  kscc_in_t s_data,
    input  logic     s_valid,
    output logic     s_ready,
    output kscc_op_t q_data,
    output logic     q_valid,
    input  logic     q_ready
);

    kscc_op_t   fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    kscc_op_t   op;
    logic       push, pop;

    always_comb begin
        op.cmd      = CMD_NONE;
        op.is_digit = 1'b0;
        op.digit    = 4'd0;
        if (!s_data.mode) begin
            op.cmd = CMD_TICK;
        end else begin
            if (s_data.key_code == KEY_SET)    op.cmd = CMD_SET;
            if (s_data.key_code == KEY_TOGGLE) op.cmd = CMD_TOGGLE;
            case (s_data.key_code)
                5'd14: begin op.is_digit = 1'b1; op.digit = 4'd0; end
                5'd1, 5'd2, 5'd3: begin
                    op.is_digit = 1'b1; op.digit = s_data.key_code[3:0];
                end
                5'd5, 5'd6, 5'd7: begin
                    op.is_digit = 1'b1; op.digit = s_data.key_code[3:0] - 4'd1;
                end
                5'd9, 5'd10, 5'd11: begin
                    op.is_digit = 1'b1; op.digit = s_data.key_code[3:0] - 4'd2;
                end
                default: ;
            endcase
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wr_ptr_reg] <= op;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_valid_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid == (cnt_reg != 2'd0)) else $error("queue valid mismatch");
`endif

endmodule

[hdl/kscc_back.sv]
// Back end: executes ops on the calendar and entry state, holds the result
// register. Depends on kscc_pkg.
module kscc_back import kscc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  kscc_op_t  q_data,
    input  logic      q_valid,
    output logic      q_ready,
    output kscc_out_t m_data,
    output logic      m_valid,
    input  logic      m_ready
);

    logic [6:0]  yhi_reg, yhi_next, ylo_reg, ylo_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next, hour_reg, hour_next;
    logic [5:0]  min_reg, min_next, sec_reg, sec_next;
    logic        t12_reg, t12_next;
    logic [1:0]  phase_reg, phase_next;
    logic [26:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [6:0]  p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next, p3_reg, p3_next;
    logic [6:0]  part_cur, part_new;
    logic [2:0]  err;
    logic [26:0] acc_new;
    logic [3:0]  cnt_new;
    logic [13:0] year_out;
    logic [4:0]  shown;
    logic        pm, take;
    kscc_out_t   res_reg;
    logic        mv_reg;

    function automatic logic [6:0] times_ten_plus(input logic [6:0] p, input logic [3:0] d);
        return 7'({p, 3'b000} + {2'b00, p, 1'b0} + {6'd0, d});
    endfunction

    assign take    = q_valid && (!mv_reg || m_ready);
    assign q_ready = !mv_reg || m_ready;

    assign acc_new = 27'((acc_reg << 3) + (acc_reg << 1) + {23'd0, q_data.digit});
    assign cnt_new = cnt_reg + 4'd1;

    // digit pairs: month/hour, day/minute, century/second, year-in-century
    always_comb begin
        case (cnt_reg[2:1])
            2'd0:    part_cur = p0_reg;
            2'd1:    part_cur = p1_reg;
            2'd2:    part_cur = p2_reg;
            default: part_cur = p3_reg;
        endcase
        part_new = times_ten_plus(part_cur, q_data.digit);
    end

    always_comb begin
        yhi_next = yhi_reg; ylo_next = ylo_reg; month_next = month_reg; day_next = day_reg;
        hour_next = hour_reg; min_next = min_reg; sec_next = sec_reg;
        t12_next = t12_reg; phase_next = phase_reg;
        acc_next = acc_reg; cnt_next = cnt_reg; err = ERR_NONE;
        p0_next = p0_reg; p1_next = p1_reg; p2_next = p2_reg; p3_next = p3_reg;
        if (phase_reg == PH_RUN) begin
            unique case (q_data.cmd)
                CMD_TICK: begin
                    if (sec_reg != 6'd59) sec_next = sec_reg + 6'd1;
                    else begin
                        sec_next = 6'd0;
                        if (min_reg != 6'd59) min_next = min_reg + 6'd1;
                        else begin
                            min_next = 6'd0;
                            if (hour_reg < 5'd23) hour_next = hour_reg + 5'd1;
                            else begin
                                hour_next = 5'd0;
                                if (day_reg < month_len(month_reg, is_leap(yhi_reg, ylo_reg)))
                                    day_next = day_reg + 5'd1;
                                else begin
                                    day_next = 5'd1;
                                    if (month_reg < 4'd12) month_next = month_reg + 4'd1;
                                    else begin
                                        month_next = 4'd1;
                                        if (ylo_reg != YEAR_PART_MAX) begin
                                            ylo_next = ylo_reg + 7'd1;
                                        end else if (yhi_reg != YEAR_PART_MAX) begin
                                            ylo_next = 7'd0;
                                            yhi_next = yhi_reg + 7'd1;
                                        end else begin
                                            ylo_next = YEAR_LO_MIN;
                                            yhi_next = YEAR_HI_MIN;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                CMD_SET: begin
                    phase_next = PH_DATE; acc_next = '0; cnt_next = '0;
                    p0_next = '0; p1_next = '0; p2_next = '0; p3_next = '0;
                end
                CMD_TOGGLE: t12_next = ~t12_reg;
                default: ;
            endcase
        end else if (q_data.is_digit) begin
            acc_next = acc_new;
            cnt_next = cnt_new;
            case (cnt_reg[2:1])
                2'd0:    p0_next = part_new;
                2'd1:    p1_next = part_new;
                2'd2:    p2_next = part_new;
                default: p3_next = part_new;
            endcase
            if (cnt_new >= ((phase_reg == PH_DATE) ? 4'd8 : 4'd6)) begin
                acc_next = '0; cnt_next = '0;
                p0_next = '0; p1_next = '0; p2_next = '0; p3_next = '0;
                if (phase_reg == PH_DATE) begin
                    if (p2_reg < YEAR_HI_MIN || (p2_reg == YEAR_HI_MIN && part_new < YEAR_LO_MIN))
                        err = ERR_YEAR;
                    else if (p0_reg == 7'd0 || p0_reg > 7'd12)
                        err = ERR_MONTH;
                    else if (p1_reg == 7'd0 ||
                             p1_reg > {2'd0, month_len(p0_reg[3:0], is_leap(p2_reg, part_new))})
                        err = ERR_DAY;
                    else begin
                        yhi_next = p2_reg; ylo_next = part_new;
                        month_next = p0_reg[3:0]; day_next = p1_reg[4:0];
                        phase_next = PH_TIME;
                    end
                end else begin
                    if (p0_reg > 7'd23) err = ERR_HOUR;
                    else if (p1_reg > 7'd59) err = ERR_MINUTE;
                    else if (part_new > 7'd59) err = ERR_SECOND;
                    else begin
                        hour_next = p0_reg[4:0]; min_next = p1_reg[5:0];
                        sec_next = part_new[5:0];
                        phase_next = PH_RUN;
                    end
                end
            end
        end
    end

    assign year_out = 14'({1'b0, yhi_next, 6'b0} + {2'b0, yhi_next, 5'b0}
                          + {5'b0, yhi_next, 2'b0} + {7'b0, ylo_next});

    always_comb begin
        shown = hour_next;
        pm    = 1'b0;
        if (t12_next) begin
            pm = (hour_next >= 5'd12);
            shown = pm ? hour_next - 5'd12 : hour_next;
            if (shown == 5'd0) shown = 5'd12;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg.year <= year_out;   res_reg.month <= month_next;
            res_reg.day <= day_next;    res_reg.hour <= shown;
            res_reg.minute <= min_next; res_reg.second <= sec_next;
            res_reg.pm_flag <= pm;      res_reg.twelve_hour <= t12_next;
            res_reg.phase <= phase_next; res_reg.digits_entered <= cnt_next;
            res_reg.entry_value <= acc_next; res_reg.error_code <= err;
        end
        if (!aresetn) begin
            yhi_reg <= 7'd20; ylo_reg <= 7'd19; month_reg <= 4'd12; day_reg <= 5'd31;
            hour_reg <= 5'd23; min_reg <= 6'd59; sec_reg <= 6'd55;
            t12_reg <= 1'b0; phase_reg <= PH_RUN; acc_reg <= '0; cnt_reg <= '0;
            p0_reg <= '0; p1_reg <= '0; p2_reg <= '0; p3_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            if (take) begin
                yhi_reg <= yhi_next; ylo_reg <= ylo_next;
                month_reg <= month_next; day_reg <= day_next;
                hour_reg <= hour_next; min_reg <= min_next; sec_reg <= sec_next;
                t12_reg <= t12_next; phase_reg <= phase_next;
                acc_reg <= acc_next; cnt_reg <= cnt_next;
                p0_reg <= p0_next; p1_reg <= p1_next; p2_reg <= p2_next; p3_reg <= p3_next;
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    assign m_data  = res_reg;
    assign m_valid = mv_reg;

`ifndef SYNTHESIS
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3) else $error("bad phase");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 4'd7) else $error("digit count too high");
    a_run_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_RUN |-> cnt_reg == 4'd0) else $error("digits while running");
    a_sec: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_reg <= 6'd59 && min_reg <= 6'd59 && hour_reg <= 5'd23)
        else $error("time out of range");
`endif

endmodule

[hdl/keypad_set_calendar_clock.sv]
// Top level of the keypad-set calendar clock.
// Depends on kscc_pkg, kscc_front, kscc_back.
//
//   channel | ports                       | payload
//   input   | s_valid s_ready s_data      | kscc_in_t  (mode, key_code)
//   result  | m_valid m_ready m_data      | kscc_out_t (calendar, entry, error)
//
// One item per cycle sustained while the result side accepts; each item passes the decode queue, then
// the execute stage that updates the state and loads the result register.
// The two-entry queue lets input keep flowing for two items while the result
// side stalls. Synchronous active-low reset restores 2019-12-31 23:59:55.
module keypad_set_calendar_clock import kscc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  kscc_in_t  s_data,
    input  logic      s_valid,
    output logic      s_ready,
    output kscc_out_t m_data,
    output logic      m_valid,
    input  logic      m_ready
);

    kscc_op_t q_data;
    logic     q_valid, q_ready;

    kscc_front u_front (
        .aclk, .aresetn, .s_data, .s_valid, .s_ready,
        .q_data, .q_valid, .q_ready
    );

    kscc_back u_back (
        .aclk, .aresetn, .q_data, .q_valid, .q_ready,
        .m_data, .m_valid, .m_ready
    );

endmodule
